[rtl/ccm_pkg.sv]
// Shared types, widths and helpers for the column covariance matrix core.
// No dependencies; used by every module of the block.
package ccm_pkg;

  localparam int DEF_MAX_ASSETS = 8;
  localparam int DEF_MAX_ROWS   = 256;

  localparam int SAMPLE_W = 24;  // Q4.20 sample
  localparam int SUM_W    = 32;  // column sum
  localparam int MEAN_W   = 25;  // column mean
  localparam int CTR_W    = 26;  // centred sample
  localparam int PROD_W   = 52;  // Q.40 cross-product
  localparam int ACC_W    = 64;  // accumulated sum, covariance
  localparam int COL_W    = 3;   // asset index
  localparam int NA_W     = 4;   // asset count

  typedef enum logic [1:0] {
    CODE_OK      = 2'd0,
    CODE_FEW     = 2'd1,
    CODE_PARTIAL = 2'd2,
    CODE_OVF     = 2'd3
  } code_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_set;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]        row_asset;
    logic [COL_W-1:0]        col_asset;
    logic signed [ACC_W-1:0] covariance;
    code_t                   status;
    logic                    last_result;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MEAN_GO, S_MEAN_WAIT, S_PAIR_A, S_PAIR_B,
    S_MAC_WAIT, S_COV_GO, S_COV_WAIT, S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             clear_load;
    logic             div_start;
    logic             div_cov;    // 1: acc / (n-1), 0: sum / n
    logic             mean_wr;
    logic             mean_ld_a;
    logic             mean_ld_b;
    logic             mac_start;
    logic             emit;
    code_t            code;
    logic             last;
    logic [COL_W-1:0] ci;
    logic [COL_W-1:0] cj;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [NA_W-1:0] n_act;
    logic            ovf;
    logic            partial;
    logic            few;
    logic            div_busy;
    logic            mac_busy;
  } stat_t;

  // Out-of-range asset count: zero acts as one, above max acts as max.
  function automatic logic [NA_W-1:0] active_assets(input logic [NA_W-1:0] na,
                                                     input int max_assets);
    logic [NA_W-1:0] r;
    if (na == '0) r = NA_W'(1);
    else if (na > NA_W'(max_assets)) r = NA_W'(max_assets);
    else r = na;
    return r;
  endfunction

endpackage

[rtl/ccm_divider.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on ccm_pkg.
module ccm_divider #(
  parameter int DVS_W = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ccm_pkg::ACC_W-1:0] dividend,
  input  logic [DVS_W-1:0]                 divisor,
  output logic                             busy,
  output logic signed [ccm_pkg::ACC_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ccm_pkg::ACC_W + 1);

  logic [ccm_pkg::ACC_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W:0]            rem_r, rem_nxt;
  logic [DVS_W-1:0]          dvs_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      neg_r;
  logic [DVS_W:0]            rem_sh;
  logic                      fits;

  always_comb begin
    rem_sh   = {rem_r[DVS_W-1:0], dvd_r[ccm_pkg::ACC_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    rem_nxt  = fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
    dvd_nxt  = {dvd_r[ccm_pkg::ACC_W-2:0], fits};
    cnt_nxt  = cnt_r - CNT_W'(1);
    busy_nxt = cnt_nxt != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(ccm_pkg::ACC_W);
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[ccm_pkg::ACC_W-1] ? -dividend : dividend;
      neg_r <= dividend[ccm_pkg::ACC_W-1];
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -signed'(dvd_r) : signed'(dvd_r);

endmodule

[rtl/ccm_datapath.sv]
// Datapath: sample store, column sums, load counters, means, MAC pipeline, divider.
// Depends on ccm_pkg and ccm_divider.
module ccm_datapath #(
  parameter int MAX_ASSETS = ccm_pkg::DEF_MAX_ASSETS,
  parameter int MAX_ROWS   = ccm_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ld_en,
  input  ccm_pkg::in_t                 ld_data,
  input  logic                         cfg_we,
  input  logic [ccm_pkg::NA_W-1:0]     cfg_wdata,
  input  ccm_pkg::cmd_t                cmd,
  output ccm_pkg::stat_t               stat,
  output logic                         out_valid,
  output ccm_pkg::out_t                out_data
);

  localparam int DEPTH = MAX_ROWS * MAX_ASSETS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CIW   = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;

  logic [ccm_pkg::NA_W-1:0] num_assets_r;
  logic [ccm_pkg::NA_W-1:0] n_act;

  logic signed [ccm_pkg::SAMPLE_W-1:0] store [DEPTH];
  logic signed [ccm_pkg::SUM_W-1:0]    sums_r [MAX_ASSETS];
  logic signed [ccm_pkg::MEAN_W-1:0]   mean_r [MAX_ASSETS];

  logic [ccm_pkg::COL_W-1:0] pos_r;
  logic [RCW-1:0]            rows_r;
  logic                      ovf_r;

  logic [ccm_pkg::NA_W-1:0]  col_ext, col_inc;
  logic                      rows_full;
  logic [AW-1:0]             wr_addr;
  logic [CIW-1:0]            sum_idx;
  logic signed [ccm_pkg::SUM_W-1:0] sum_rd;

  // MAC pipeline
  logic [RIW-1:0]  r_r;
  logic            issuing_r, v1_r, v2_r, v3_r;
  logic [AW-1:0]   addr_a, addr_b;
  logic signed [ccm_pkg::SAMPLE_W-1:0] rd_a_r, rd_b_r;
  logic signed [ccm_pkg::MEAN_W-1:0]   mean_a_r, mean_b_r;
  logic signed [ccm_pkg::CTR_W-1:0]    ca_r, cb_r;
  logic signed [ccm_pkg::PROD_W-1:0]   prod_r;
  logic signed [ccm_pkg::ACC_W-1:0]    acc_r;

  // divider
  logic signed [ccm_pkg::ACC_W-1:0] div_dvd, div_q;
  logic [RCW-1:0]                   div_dvs;
  logic                             div_busy;

  assign n_act     = ccm_pkg::active_assets(num_assets_r, MAX_ASSETS);
  assign col_ext   = {1'b0, pos_r};
  assign col_inc   = col_ext + ccm_pkg::NA_W'(1);
  assign rows_full = rows_r == RCW'(MAX_ROWS);
  assign wr_addr   = AW'(rows_r[RIW-1:0]) * AW'(MAX_ASSETS) + AW'(pos_r);
  assign sum_idx   = ld_en ? pos_r[CIW-1:0] : cmd.ci[CIW-1:0];
  assign sum_rd    = sums_r[sum_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) num_assets_r <= ccm_pkg::NA_W'(ccm_pkg::DEF_MAX_ASSETS);
    else if (cfg_we) num_assets_r <= cfg_wdata;
  end

  // load state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_load) begin
      pos_r  <= '0;
      rows_r <= '0;
      ovf_r  <= 1'b0;
      for (int k = 0; k < MAX_ASSETS; k++) sums_r[k] <= '0;
    end else if (ld_en) begin
      if (rows_full) begin
        ovf_r <= 1'b1;
      end else begin
        if (col_ext < n_act)
          sums_r[sum_idx] <= sum_rd + ccm_pkg::SUM_W'(ld_data.sample_value);
        if (col_inc >= n_act) begin
          pos_r  <= '0;
          rows_r <= rows_r + RCW'(1);
        end else begin
          pos_r <= col_inc[ccm_pkg::COL_W-1:0];
        end
      end
    end
  end

  // sample store: one write port, two registered read ports
  assign addr_a = AW'(r_r) * AW'(MAX_ASSETS) + AW'(cmd.ci);
  assign addr_b = AW'(r_r) * AW'(MAX_ASSETS) + AW'(cmd.cj);

  always_ff @(posedge clk) begin
    if (ld_en && !rows_full && col_ext < n_act) store[wr_addr] <= ld_data.sample_value;
    rd_a_r <= store[addr_a];
    rd_b_r <= store[addr_b];
  end

  // means: one write port and two read ports (by ci and by cj)
  always_ff @(posedge clk) begin
    if (cmd.mean_wr)   mean_r[cmd.ci[CIW-1:0]] <= div_q[ccm_pkg::MEAN_W-1:0];
    if (cmd.mean_ld_a) mean_a_r <= mean_r[cmd.ci[CIW-1:0]];
    if (cmd.mean_ld_b) mean_b_r <= mean_r[cmd.cj[CIW-1:0]];
  end

  // MAC control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      r_r       <= '0;
    end else begin
      v1_r <= issuing_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.mac_start) begin
        issuing_r <= 1'b1;
        r_r       <= '0;
      end else if (issuing_r) begin
        if (RCW'(r_r) == rows_r - RCW'(1)) issuing_r <= 1'b0;
        else r_r <= r_r + RIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    ca_r   <= ccm_pkg::CTR_W'(rd_a_r) - ccm_pkg::CTR_W'(mean_a_r);
    cb_r   <= ccm_pkg::CTR_W'(rd_b_r) - ccm_pkg::CTR_W'(mean_b_r);
    prod_r <= ca_r * cb_r;
    if (cmd.mac_start) acc_r <= '0;
    else if (v3_r)     acc_r <= acc_r + ccm_pkg::ACC_W'(prod_r);
  end

  // shared divider: means then covariances
  assign div_dvd = cmd.div_cov ? acc_r : ccm_pkg::ACC_W'(sum_rd);
  assign div_dvs = cmd.div_cov ? rows_r - RCW'(1) : rows_r;

  ccm_divider #(.DVS_W(RCW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status      <= cmd.code;
      out_data.last_result <= cmd.last;
      if (cmd.code == ccm_pkg::CODE_OK) begin
        out_data.row_asset  <= cmd.ci;
        out_data.col_asset  <= cmd.cj;
        out_data.covariance <= div_q;
      end else begin
        out_data.row_asset  <= '0;
        out_data.col_asset  <= '0;
        out_data.covariance <= '0;
      end
    end
  end

  assign stat.n_act    = n_act;
  assign stat.ovf      = ovf_r;
  assign stat.partial  = pos_r != '0;
  assign stat.few      = rows_r < RCW'(2);
  assign stat.div_busy = div_busy;
  assign stat.mac_busy = issuing_r | v1_r | v2_r | v3_r;

endmodule

[rtl/ccm_ctrl.sv]
// Controller state machine: load, checks, means, per-pair MAC and divide, emit.
// Depends on ccm_pkg.
module ccm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld_en,
  input  logic           ld_last,
  input  ccm_pkg::stat_t stat,
  output ccm_pkg::cmd_t  cmd,
  output logic           busy
);

  ccm_pkg::state_t          state_r, state_nxt;
  logic [ccm_pkg::COL_W-1:0] ci_r, ci_nxt, cj_r, cj_nxt;
  logic                      ci_end, cj_end;
  ccm_pkg::code_t            err;

  assign ci_end = {1'b0, ci_r} == stat.n_act - ccm_pkg::NA_W'(1);
  assign cj_end = {1'b0, cj_r} == stat.n_act - ccm_pkg::NA_W'(1);

  always_comb begin
    if (stat.ovf)          err = ccm_pkg::CODE_OVF;
    else if (stat.partial) err = ccm_pkg::CODE_PARTIAL;
    else if (stat.few)     err = ccm_pkg::CODE_FEW;
    else                   err = ccm_pkg::CODE_OK;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    unique case (state_r)
      ccm_pkg::S_IDLE: begin
        if (ld_en && ld_last) state_nxt = ccm_pkg::S_CHECK;
      end
      ccm_pkg::S_CHECK: begin
        ci_nxt = '0;
        cj_nxt = '0;
        state_nxt = (err == ccm_pkg::CODE_OK) ? ccm_pkg::S_MEAN_GO : ccm_pkg::S_IDLE;
      end
      ccm_pkg::S_MEAN_GO: state_nxt = ccm_pkg::S_MEAN_WAIT;
      ccm_pkg::S_MEAN_WAIT: begin
        if (!stat.div_busy) begin
          if (ci_end) begin
            ci_nxt    = '0;
            state_nxt = ccm_pkg::S_PAIR_A;
          end else begin
            ci_nxt    = ci_r + ccm_pkg::COL_W'(1);
            state_nxt = ccm_pkg::S_MEAN_GO;
          end
        end
      end
      ccm_pkg::S_PAIR_A: state_nxt = ccm_pkg::S_PAIR_B;
      ccm_pkg::S_PAIR_B: state_nxt = ccm_pkg::S_MAC_WAIT;
      ccm_pkg::S_MAC_WAIT: begin
        if (!stat.mac_busy) state_nxt = ccm_pkg::S_COV_GO;
      end
      ccm_pkg::S_COV_GO: state_nxt = ccm_pkg::S_COV_WAIT;
      ccm_pkg::S_COV_WAIT: begin
        if (!stat.div_busy) state_nxt = ccm_pkg::S_EMIT;
      end
      ccm_pkg::S_EMIT: begin
        if (cj_end) begin
          cj_nxt = '0;
          ci_nxt = ci_r + ccm_pkg::COL_W'(1);
        end else begin
          cj_nxt = cj_r + ccm_pkg::COL_W'(1);
        end
        state_nxt = (ci_end && cj_end) ? ccm_pkg::S_IDLE : ccm_pkg::S_PAIR_A;
      end
      default: state_nxt = ccm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.ci   = ci_r;
    cmd.cj   = cj_r;
    cmd.code = ccm_pkg::CODE_OK;
    busy     = state_r != ccm_pkg::S_IDLE;
    unique case (state_r)
      ccm_pkg::S_IDLE: ;
      ccm_pkg::S_CHECK: begin
        if (err != ccm_pkg::CODE_OK) begin
          cmd.emit       = 1'b1;
          cmd.code       = err;
          cmd.last       = 1'b1;
          cmd.clear_load = 1'b1;
        end
      end
      ccm_pkg::S_MEAN_GO:   cmd.div_start = 1'b1;
      ccm_pkg::S_MEAN_WAIT: cmd.mean_wr = !stat.div_busy;
      ccm_pkg::S_PAIR_A:    cmd.mean_ld_a = 1'b1;
      ccm_pkg::S_PAIR_B: begin
        cmd.mean_ld_b = 1'b1;
        cmd.mac_start = 1'b1;
      end
      ccm_pkg::S_MAC_WAIT: ;
      ccm_pkg::S_COV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_cov   = 1'b1;
      end
      ccm_pkg::S_COV_WAIT: cmd.div_cov = 1'b1;
      ccm_pkg::S_EMIT: begin
        cmd.div_cov    = 1'b1;
        cmd.emit       = 1'b1;
        cmd.last       = ci_end && cj_end;
        cmd.clear_load = ci_end && cj_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccm_pkg::S_IDLE;
      ci_r    <= '0;
      cj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
    end
  end

endmodule

[rtl/column_covariance_matrix_core.sv]
// Top level of the column covariance matrix core: controller plus datapath.
// Depends on ccm_pkg, ccm_ctrl, ccm_datapath (and ccm_divider below it).
//
//  Channel  | Ports                   | Transfer when
//  ---------+-------------------------+-------------------------------
//  input    | start, busy, in_data    | start high and busy low
//  result   | out_valid, out_data     | every cycle out_valid is high
//  config   | cfg_we, cfg_wdata       | cfg_we high (num_assets)
//
// Loading: one sample per cycle, back to back, busy stays low.
// A sample with end_of_set raises busy: a check state (a failed check emits
// an error result and ends the run), then per column a divide for the mean,
// then per (row, col) pair a MAC pipeline pass plus a divide; the shared
// divider (one quotient bit a cycle) sets most of the run length.
// Reset (rst_n low, synchronous) clears load state and sets num_assets to 8;
// the sample store is not cleared. Results cannot be stalled by the receiver.
module column_covariance_matrix_core #(
  parameter int MAX_ASSETS = ccm_pkg::DEF_MAX_ASSETS,
  parameter int MAX_ROWS   = ccm_pkg::DEF_MAX_ROWS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  ccm_pkg::in_t             in_data,
  output logic                     out_valid,
  output ccm_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [ccm_pkg::NA_W-1:0] cfg_wdata
);

  ccm_pkg::cmd_t  cmd;
  ccm_pkg::stat_t stat;
  logic           ld_en;

  // a sample is taken only while the controller is idle
  assign ld_en = start && !busy;

  ccm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (ld_en),
    .ld_last (in_data.end_of_set),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ccm_datapath #(
    .MAX_ASSETS (MAX_ASSETS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_en     (ld_en),
    .ld_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/ccm_checker.sv]
// Result checker for the column covariance matrix core: follows the input,
// result and config transfers, predicts covariance entries and error results, compares them.
// Depends on ccm_pkg.
module ccm_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  ccm_pkg::in_t             in_data,
  input  logic                     out_valid,
  input  ccm_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [ccm_pkg::NA_W-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending,
  output int                       entries_seen
);

  localparam int MAXA = ccm_pkg::DEF_MAX_ASSETS;
  localparam int MAXR = ccm_pkg::DEF_MAX_ROWS;

  logic signed [ccm_pkg::SAMPLE_W-1:0] samples [MAXR*MAXA];
  logic signed [63:0]                  col_sum [MAXA];
  int                                  col_pos;
  int                                  rows;
  logic                                ovf_seen;
  logic [ccm_pkg::NA_W-1:0]            assets_reg;
  ccm_pkg::out_t                       cov_queue [$];

  function automatic int eff_assets();
    int n;
    n = assets_reg;
    if (n == 0) n = 1;
    if (n > MAXA) n = MAXA;
    return n;
  endfunction

  task automatic restart_set();
    for (int c = 0; c < MAXA; c++) col_sum[c] = '0;
    col_pos = 0;
    rows = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic push_error(input ccm_pkg::code_t c);
    ccm_pkg::out_t e;
    e = '0;
    e.status = c;
    e.last_result = 1'b1;
    cov_queue.push_back(e);
    restart_set();
  endtask

  task automatic take_sample(input ccm_pkg::in_t s);
    int na;
    logic signed [63:0] mu [MAXA];
    logic signed [63:0] acc, a, b;
    ccm_pkg::out_t e;
    na = eff_assets();
    if (rows >= MAXR) begin
      ovf_seen = 1'b1;
    end else begin
      if (col_pos < na) begin
        samples[rows*MAXA + col_pos] = s.sample_value;
        col_sum[col_pos] += 64'(s.sample_value);
      end
      if (col_pos + 1 >= na) begin
        col_pos = 0;
        rows++;
      end else begin
        col_pos = (col_pos + 1) & 7;
      end
    end
    if (!s.end_of_set) return;
    if (ovf_seen) push_error(ccm_pkg::CODE_OVF);
    else if (col_pos != 0) push_error(ccm_pkg::CODE_PARTIAL);
    else if (rows < 2) push_error(ccm_pkg::CODE_FEW);
    else begin
      for (int i = 0; i < na; i++) mu[i] = col_sum[i] / 64'(rows);
      for (int i = 0; i < na; i++) begin
        for (int j = 0; j < na; j++) begin
          acc = '0;
          for (int r = 0; r < rows; r++) begin
            a = 64'(samples[r*MAXA + i]) - mu[i];
            b = 64'(samples[r*MAXA + j]) - mu[j];
            acc += a * b;
          end
          e.row_asset = ccm_pkg::COL_W'(i);
          e.col_asset = ccm_pkg::COL_W'(j);
          e.covariance = acc / 64'(rows - 1);
          e.status = ccm_pkg::CODE_OK;
          e.last_result = (i == na-1) && (j == na-1);
          cov_queue.push_back(e);
        end
      end
      restart_set();
    end
  endtask

  always @(posedge clk) begin
    ccm_pkg::out_t exp_e;
    if (!rst_n) begin
      restart_set();
      assets_reg <= ccm_pkg::NA_W'(MAXA);
      fail_count <= 0;
      entries_seen <= 0;
      pending <= 0;
      cov_queue.delete();
    end else begin
      // results first: a result and a new transfer may share an edge
      if (out_valid) begin
        entries_seen <= entries_seen + 1;
        if (cov_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_e = cov_queue.pop_front();
          if (out_data.row_asset !== exp_e.row_asset ||
              out_data.col_asset !== exp_e.col_asset ||
              out_data.covariance !== exp_e.covariance ||
              out_data.status !== exp_e.status ||
              out_data.last_result !== exp_e.last_result) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) take_sample(in_data);
      if (cfg_we) assets_reg <= cfg_wdata;
      pending <= cov_queue.size();
    end
  end

endmodule

[tb/testbench.sv]
// Stimulus and verdict for the column covariance matrix core.
// Depends on ccm_pkg, column_covariance_matrix_core and ccm_checker.
module testbench;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  ccm_pkg::in_t             in_data = '0;
  logic                     out_valid;
  ccm_pkg::out_t            out_data;
  logic                     cfg_we = 1'b0;
  logic [ccm_pkg::NA_W-1:0] cfg_wdata = '0;
  int                       fail_count, pending, entries_seen;
  int                       idle_cycles = 0;
  int                       samples_sent = 0;
  int                       sets_done = 0;
  bit                       in_held = 1'b0;

  // longest quiet stretch: means plus first pair of a full-depth set
  localparam int WATCHDOG = 20000;

  always #6 clk = ~clk;

  column_covariance_matrix_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ccm_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .entries_seen(entries_seen)
  );

  // Watchdog: cycles with no transfer of any kind.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drop start once, only if it is still held from the last transfer.
  task automatic release_input();
    if (in_held) begin
      start <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  // One sample transfer; the sender gap is drawn at random per item,
  // with gap-free stretches when 'burst' is set. start stays high across
  // back-to-back transfers.
  task automatic send_sample(input logic signed [ccm_pkg::SAMPLE_W-1:0] v, input logic eos,
                             input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      release_input();
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_held = 1'b1;
    in_data.sample_value <= v;
    in_data.end_of_set <= eos;
    @(posedge clk);
    while (busy) @(posedge clk);
    samples_sent++;
  endtask

  // Config writes only once the core is idle and nothing is owed.
  task automatic write_assets(input logic [ccm_pkg::NA_W-1:0] n);
    release_input();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [ccm_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return ccm_pkg::SAMPLE_W'($urandom_range(0, 255)) - 24'sd128;
      default: return ccm_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // A well-formed set of 'nrows' rows at 'na' columns, ending the set.
  task automatic send_set(input int na, input int nrows, input bit extremes);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    for (int r = 0; r < nrows; r++)
      for (int c = 0; c < na; c++)
        send_sample(extremes ? ((r + c) % 2 ? 24'sh7FFFFF : 24'sh800000) : rand_sample(),
                    (r == nrows-1) && (c == na-1), burst);
    sets_done++;
  endtask

  initial begin
    int na;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset width of 8 with two rows of extremes
    send_set(8, 2, 1'b1);
    write_assets(4'd1);
    send_set(1, 3, 1'b1);               // single asset, extremes
    send_sample(24'sd5, 1'b1, 1'b0);    // fewer than two rows
    write_assets(4'd3);
    send_sample(24'sd1, 1'b0, 1'b0);
    send_sample(24'sd2, 1'b1, 1'b0);    // partial last row
    write_assets(4'd0);                 // zero acts as one
    send_set(1, 2, 1'b0);
    write_assets(4'd15);                // above max acts as eight
    send_set(8, 2, 1'b0);
    // Overflow: 257 rows at one asset, the extra sample discarded
    write_assets(4'd1);
    for (int i = 0; i < ccm_pkg::DEF_MAX_ROWS + 1; i++)
      send_sample(rand_sample(), i == ccm_pkg::DEF_MAX_ROWS, 1'b1);
    // Mid-set width change: a row of 2 then a row of 1 under the new width
    write_assets(4'd2);
    send_sample(24'sd100, 1'b0, 1'b0);
    send_sample(-24'sd100, 1'b0, 1'b0);
    write_assets(4'd1);
    send_sample(24'sd7, 1'b1, 1'b0);

    // Random: mostly well-formed small sets, some broken ones
    while (samples_sent < 340) begin
      na = $urandom_range(1, 8);
      write_assets(ccm_pkg::NA_W'(na));
      case ($urandom_range(0, 9))
        0: send_sample(rand_sample(), 1'b1, 1'b0);            // too few / partial
        1: begin
          send_sample(rand_sample(), 1'b0, 1'b0);
          send_sample(rand_sample(), (na != 2), 1'b0);
          if (na == 2) send_sample(rand_sample(), 1'b1, 1'b0);
        end
        default: send_set(na, $urandom_range(2, 6), 1'b0);
      endcase
    end

    release_input();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d samples in %0d full sets; %0d results checked.",
             samples_sent, sets_done, entries_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
